>>> rtl/ledcds_pkg.sv
// LED chain sequencer package: command codes, item and result types, chain helpers.
// Used by every module of the sequencer; no dependencies.
`timescale 1ns / 1ps

package ledcds_pkg;

  localparam int MAX_LEDS  = 16;
  localparam int LED_W     = 16;
  localparam int CHAIN_CAP = (MAX_LEDS < LED_W) ? MAX_LEDS : LED_W;

  localparam logic [2:0] ACT_TICK      = 3'd0;
  localparam logic [2:0] ACT_PULSE     = 3'd1;
  localparam logic [2:0] ACT_ON        = 3'd2;
  localparam logic [2:0] ACT_OFF       = 3'd3;
  localparam logic [2:0] ACT_ALL_ONOFF = 3'd4;
  localparam logic [2:0] ACT_ALL_OFFON = 3'd5;

  localparam logic [2:0] ADDR_LED_COUNT = 3'd0;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_WALK  = 4'b0010,
    PH_ALL_A = 4'b0100,
    PH_ALL_B = 4'b1000
  } ledcds_phase_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         first_led;
    logic [3:0]         last_led;
    logic               reverse;
    logic [7:0]         skip;
    logic signed [15:0] step_delay;
    logic signed [15:0] end_delay;
    logic [7:0]         repeats;
    logic               load_delay;
    logic signed [15:0] base_value;
  } ledcds_item_t;

  typedef struct packed {
    logic [LED_W-1:0]   led_levels;
    logic               busy_res;
    logic signed [15:0] running_delay;
    logic               finished;
  } ledcds_res_t;

  function automatic logic [4:0] chain_len(input logic [4:0] cnt);
    logic [4:0] c;
    c = (cnt == 5'd0) ? 5'd1 : cnt;
    if (c > 5'(CHAIN_CAP)) c = 5'(CHAIN_CAP);
    return c;
  endfunction

  function automatic logic [LED_W-1:0] chain_mask(input logic [4:0] n);
    logic [LED_W-1:0] m;
    if (n >= 5'(LED_W)) m = '1;
    else m = (LED_W'(1) << n[3:0]) - LED_W'(1);
    return m;
  endfunction

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [16:0] s;
    logic signed [15:0] r;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) r = s[16] ? 16'sh8000 : 16'sh7fff;
    else r = s[15:0];
    return r;
  endfunction

  function automatic logic [LED_W-1:0] led_act(input logic [LED_W-1:0] lv,
                                               input logic [LED_W-1:0] bitm,
                                               input logic [2:0] kind);
    logic [LED_W-1:0] r;
    case (kind)
      ACT_PULSE: r = lv ^ bitm;
      ACT_ON:    r = lv | bitm;
      default:   r = lv & ~bitm;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ledcds_in_stage.sv
// LED chain sequencer input register: captures one transaction and holds it
// until the sequencer core takes it. Depends on ledcds_pkg.
`timescale 1ns / 1ps

module ledcds_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ledcds_pkg::ledcds_item_t in_item,
  input  logic                 take,
  output logic                 s1_valid,
  output ledcds_pkg::ledcds_item_t s1_item
);
  import ledcds_pkg::*;

  logic         valid_r, valid_nxt;
  ledcds_item_t item_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

>>> rtl/ledcds_core.sv
// LED chain sequencer core: sequence state, per-transaction update and result register.
// Depends on ledcds_pkg.
`timescale 1ns / 1ps

module ledcds_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [4:0]           led_count,
  input  logic                 s1_valid,
  input  ledcds_pkg::ledcds_item_t s1_item,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ledcds_pkg::ledcds_res_t out_res
);
  import ledcds_pkg::*;

  ledcds_phase_t      phase_r, phase_nxt;
  logic [LED_W-1:0]   levels_r, levels_nxt;
  logic [3:0]         cur_r, cur_nxt;
  logic signed [15:0] acc_r, acc_nxt;
  logic [14:0]        wait_r, wait_nxt;
  logic [7:0]         cycles_r, cycles_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic [3:0]         last_r, last_nxt;
  logic               rev_r, rev_nxt;
  logic [8:0]         stride_r, stride_nxt;
  logic signed [15:0] step_r, step_nxt;
  logic signed [15:0] end_r, end_nxt;
  logic               out_valid_r, out_valid_nxt;
  ledcds_res_t        res_r, res_nxt;

  logic [4:0]         chain_n;
  logic [LED_W-1:0]   mask;
  logic signed [15:0] acc0, cmd_sum, step_sum, end_sum;
  logic [9:0]         fwd_pos;
  logic [3:0]         rev_pos, new_pos;
  logic [LED_W-1:0]   cur_bit, new_bit, first_bit, lev_pulse;
  logic [7:0]         cycles_dec;
  logic               fin;

  assign take    = s1_valid && (!out_valid_r || out_ready);
  assign chain_n = chain_len(led_count);
  assign mask    = chain_mask(chain_n);

  assign acc0     = s1_item.load_delay ? s1_item.base_value : acc_r;
  assign cmd_sum  = sat_add(acc0, s1_item.step_delay);
  assign step_sum = sat_add(acc_r, step_r);
  assign end_sum  = sat_add(acc_r, end_r);

  assign fwd_pos    = {6'd0, cur_r} + {1'b0, stride_r};
  assign rev_pos    = cur_r - stride_r[3:0];
  assign new_pos    = rev_r ? rev_pos : fwd_pos[3:0];
  assign cur_bit    = LED_W'(1) << cur_r;
  assign new_bit    = LED_W'(1) << new_pos;
  assign first_bit  = LED_W'(1) << s1_item.first_led;
  assign lev_pulse  = (kind_r == ACT_PULSE) ? (levels_r ^ cur_bit) : levels_r;
  assign cycles_dec = cycles_r - {7'd0, (cycles_r != 8'd0)};

  always_comb begin
    phase_nxt  = phase_r;
    levels_nxt = levels_r;
    cur_nxt    = cur_r;
    acc_nxt    = acc_r;
    wait_nxt   = wait_r;
    cycles_nxt = cycles_r;
    kind_nxt   = kind_r;
    last_nxt   = last_r;
    rev_nxt    = rev_r;
    stride_nxt = stride_r;
    step_nxt   = step_r;
    end_nxt    = end_r;
    fin        = 1'b0;
    if (take) begin
      if (s1_item.action == ACT_TICK) begin
        if (phase_r != PH_IDLE) begin
          if (wait_r > 15'd1) begin
            wait_nxt = wait_r - 15'd1;
          end else begin
            wait_nxt = '0;
            case (phase_r)
              PH_WALK: begin
                levels_nxt = lev_pulse;
                if (!rev_r && (fwd_pos > {5'd0, chain_n} - 10'd1)) begin
                  fin = 1'b1;
                end else if (!rev_r && (fwd_pos == {6'd0, last_r} + 10'd1)) begin
                  fin     = 1'b1;
                  acc_nxt = end_sum;
                end else if (rev_r && ({6'd0, cur_r} < {1'b0, stride_r})) begin
                  fin = 1'b1;
                end else if (rev_r && (last_r != 4'd0) && (rev_pos == last_r - 4'd1)) begin
                  fin     = 1'b1;
                  acc_nxt = end_sum;
                end else begin
                  cur_nxt    = new_pos;
                  levels_nxt = led_act(lev_pulse, new_bit, kind_r);
                  acc_nxt    = step_sum;
                  wait_nxt   = step_sum[15] ? 15'd0 : step_sum[14:0];
                end
              end
              PH_ALL_A: begin
                levels_nxt = (kind_r == ACT_ALL_ONOFF) ? (levels_r & ~mask) : (levels_r | mask);
                acc_nxt    = step_sum;
                wait_nxt   = step_sum[15] ? 15'd0 : step_sum[14:0];
                phase_nxt  = PH_ALL_B;
              end
              PH_ALL_B: begin
                cycles_nxt = cycles_dec;
                if (cycles_dec == 8'd0) begin
                  fin = 1'b1;
                end else begin
                  levels_nxt = (kind_r == ACT_ALL_ONOFF) ? (levels_r | mask)
                                                          : (levels_r & ~mask);
                  acc_nxt    = step_sum;
                  wait_nxt   = step_sum[15] ? 15'd0 : step_sum[14:0];
                  phase_nxt  = PH_ALL_A;
                end
              end
              default: begin
                phase_nxt = PH_IDLE;
              end
            endcase
            if (fin) phase_nxt = PH_IDLE;
          end
        end
      end else if ((s1_item.action <= ACT_ALL_OFFON) && (phase_r == PH_IDLE)) begin
        acc_nxt  = acc0;
        kind_nxt = s1_item.action;
        step_nxt = s1_item.step_delay;
        if (s1_item.action <= ACT_OFF) begin
          last_nxt   = s1_item.last_led;
          rev_nxt    = s1_item.reverse;
          stride_nxt = {1'b0, s1_item.skip} + 9'd1;
          end_nxt    = s1_item.end_delay;
          if ({1'b0, s1_item.first_led} >= chain_n) begin
            fin = 1'b1;
          end else begin
            cur_nxt    = s1_item.first_led;
            levels_nxt = led_act(levels_r, first_bit, s1_item.action);
            acc_nxt    = cmd_sum;
            wait_nxt   = cmd_sum[15] ? 15'd0 : cmd_sum[14:0];
            phase_nxt  = PH_WALK;
          end
        end else begin
          cycles_nxt = (s1_item.repeats == 8'd0) ? 8'd1 : s1_item.repeats;
          levels_nxt = (s1_item.action == ACT_ALL_ONOFF) ? (levels_r | mask)
                                                         : (levels_r & ~mask);
          acc_nxt    = cmd_sum;
          wait_nxt   = cmd_sum[15] ? 15'd0 : cmd_sum[14:0];
          phase_nxt  = PH_ALL_A;
        end
      end
    end
  end

  always_comb begin
    res_nxt.led_levels    = levels_nxt;
    res_nxt.busy_res      = (phase_nxt != PH_IDLE);
    res_nxt.running_delay = acc_nxt;
    res_nxt.finished      = fin;
  end

  assign out_valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      levels_r    <= '0;
      cur_r       <= '0;
      acc_r       <= '0;
      wait_r      <= '0;
      cycles_r    <= '0;
      kind_r      <= '0;
      last_r      <= '0;
      rev_r       <= 1'b0;
      stride_r    <= '0;
      step_r      <= '0;
      end_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      levels_r    <= levels_nxt;
      cur_r       <= cur_nxt;
      acc_r       <= acc_nxt;
      wait_r      <= wait_nxt;
      cycles_r    <= cycles_nxt;
      kind_r      <= kind_nxt;
      last_r      <= last_nxt;
      rev_r       <= rev_nxt;
      stride_r    <= stride_nxt;
      step_r      <= step_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_fin_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.finished && res_r.busy_res))
    else $error("finished result still reports busy");

  a_walk_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WALK) |-> ({1'b0, cur_r} < chain_n))
    else $error("walk position outside the chain");

  a_wait_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r != 15'd0) |-> (phase_r != PH_IDLE))
    else $error("wait pending while idle");

  a_flash_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_ALL_A) || (phase_r == PH_ALL_B)) |-> (cycles_r != 8'd0))
    else $error("flash sequence running with no cycles left");

  a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!take) |=> $stable(phase_r) && $stable(levels_r) && $stable(acc_r))
    else $error("sequence state moved without a transaction");

endmodule

>>> rtl/led_chain_dance_sequencer_top.sv
// LED chain sequencer top level: ports, configuration register, pipeline assembly.
// Depends on ledcds_pkg, ledcds_in_stage and ledcds_core.
//
// Usage:
//   Input channel (in_valid/in_ready) carries ticks of 1 ms and commands:
//   pulse/on/off walks over the chain and all-on-off/all-off-on flashes.
//   Result channel (out_valid/out_ready) returns one transaction per input
//   transaction: LED levels, busy flag, running delay and a finished flag.
//   A transaction passes the input register, then the state update and result
//   register, from input acceptance to result valid. Throughput is 1 transaction
//   per cycle unless the receiver stalls; the core's state update loop sets it.
//   When the receiver stalls, the result register holds and the input
//   register takes one more transaction; after that in_ready drops.
//   APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds led_count
//   at address 0; write it only while no sequence is running. pready is
//   always high.
//   Reset (rst_n low, synchronous) turns all LEDs off, clears the running
//   delay, returns to idle, empties both registers and sets led_count to 16.
`timescale 1ns / 1ps

module led_chain_dance_sequencer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic [3:0]         in_first_led,
  input  logic [3:0]         in_last_led,
  input  logic               in_reverse,
  input  logic [7:0]         in_skip,
  input  logic signed [15:0] in_step_delay,
  input  logic signed [15:0] in_end_delay,
  input  logic [7:0]         in_repeats,
  input  logic               in_load_delay,
  input  logic signed [15:0] in_base_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_led_levels,
  output logic               out_busy_res,
  output logic signed [15:0] out_running_delay,
  output logic               out_finished,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ledcds_pkg::*;

  logic [4:0]   led_count_r, led_count_nxt;
  ledcds_item_t in_item, s1_item;
  ledcds_res_t  out_res;
  logic         s1_valid, take;
  logic         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_LED_COUNT);
  assign led_count_nxt = wr_en ? pwdata[4:0] : led_count_r;
  assign prdata = (paddr == ADDR_LED_COUNT) ? {27'd0, led_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= 5'd16;
    end else begin
      led_count_r <= led_count_nxt;
    end
  end

  always_comb begin
    in_item.action     = in_action;
    in_item.first_led  = in_first_led;
    in_item.last_led   = in_last_led;
    in_item.reverse    = in_reverse;
    in_item.skip       = in_skip;
    in_item.step_delay = in_step_delay;
    in_item.end_delay  = in_end_delay;
    in_item.repeats    = in_repeats;
    in_item.load_delay = in_load_delay;
    in_item.base_value = in_base_value;
  end

  ledcds_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ledcds_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .led_count (led_count_r),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_led_levels    = out_res.led_levels;
  assign out_busy_res      = out_res.busy_res;
  assign out_running_delay = out_res.running_delay;
  assign out_finished      = out_res.finished;

endmodule
